@@ hdl/pattern_count_soft_breaks_assert.svh @@
// ---------------------------------------------------------------------------
// pattern_count_soft_breaks_assert.svh
// Assertion macros used by the pattern counter RTL.
// ---------------------------------------------------------------------------
`ifndef PATTERN_COUNT_SOFT_BREAKS_ASSERT_SVH
`define PATTERN_COUNT_SOFT_BREAKS_ASSERT_SVH

// clocked check, off while in reset
`define PCSB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked check, also during reset
`define PCSB_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/pcsb_pkg.sv @@
// ---------------------------------------------------------------------------
// pcsb_pkg
// Types and constants of the pattern counter with soft line breaks.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pcsb_pkg;

	localparam int REG_BYTES       = 16;
	localparam int DEF_MAX_PATTERN = 16;
	localparam int LEN_W           = 5;
	localparam int CFG_W           = 64;
	localparam int COUNT_W         = 32;

	localparam logic [7:0]         NEWLINE_BYTE = 8'h0A;
	localparam logic [7:0]         HYPHEN_BYTE  = 8'h2D;
	localparam logic [LEN_W-1:0]   LEN_RESET    = 5'd1;
	localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;

	typedef enum logic [1:0] {
		REG_PAT_LOW  = 2'd0,
		REG_PAT_HIGH = 2'd1,
		REG_PAT_LEN  = 2'd2
	} cfg_reg_t;

	// per-beat data broadcast to every cell
	typedef struct packed {
		logic       adv;
		logic       last;
		logic       nl;
		logic       hy;
		logic [7:0] c;
	} bcast_t;

endpackage

@@ hdl/pattern_count_soft_breaks.sv @@
// ---------------------------------------------------------------------------
// pattern_count_soft_breaks
// Counts pattern matches in a byte stream, skipping soft line breaks.
// ---------------------------------------------------------------------------
// One text byte is taken every clock cycle unless the input is stalled; its
// result beat appears in the next cycle from the output register. The rate is
// set by the row of position cells, each of which updates its partial-match
// bit from its neighbor's bit and the broadcast byte. The input is stalled
// only while a result beat sits in the output register and the result side stalls.
// Pattern registers may be written only when no beat is in flight.
`timescale 1ns / 1ps

`include "pattern_count_soft_breaks_assert.svh"

module pattern_count_soft_breaks import pcsb_pkg::*; #(
	parameter int MAX_PATTERN = DEF_MAX_PATTERN
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               text_valid,
	output logic               text_stall,
	input  logic [7:0]         text_byte,
	input  logic               end_of_text,
	output logic               result_valid,
	input  logic               result_stall,
	output logic               match_here,
	output logic [COUNT_W-1:0] match_count,
	output logic               text_done,
	input  logic               cfg_wr_en,
	input  logic [1:0]         cfg_index,
	input  logic [CFG_W-1:0]   cfg_data
);

	localparam int NCELL = (MAX_PATTERN < REG_BYTES) ? MAX_PATTERN : REG_BYTES;

	logic [CFG_W-1:0]   pat_low_q;
	logic [CFG_W-1:0]   pat_high_q;
	logic [LEN_W-1:0]   len_q;
	logic [LEN_W-1:0]   len_used;
	logic [2*CFG_W-1:0] pat_all;

	logic [COUNT_W-1:0] cnt_q;
	logic [COUNT_W-1:0] cnt_d;
	logic               valid_q;
	logic               hit_q;
	logic [COUNT_W-1:0] count_q;
	logic               done_q;

	logic               acc;
	logic               hit;
	bcast_t             bc;

	logic [NCELL-1:0]   eq;
	logic [NCELL-1:0]   act;
	logic [NCELL-1:0]   pend;
	logic [NCELL-1:0]   done;
	logic [NCELL:0]     eq_ext;
	logic [NCELL:0]     act_ext;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q  <= '0;
			pat_high_q <= '0;
			len_q      <= LEN_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_PAT_LOW:  pat_low_q  <= cfg_data;
				REG_PAT_HIGH: pat_high_q <= cfg_data;
				REG_PAT_LEN:  len_q      <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign len_used = (len_q > LEN_W'(NCELL)) ? LEN_W'(NCELL) : len_q;
	assign pat_all  = {pat_high_q, pat_low_q};

	// handshake
	assign text_stall = valid_q && result_stall;
	assign acc        = text_valid && !text_stall;

	assign bc.adv  = acc;
	assign bc.last = end_of_text;
	assign bc.nl   = (text_byte == NEWLINE_BYTE);
	assign bc.hy   = (text_byte == HYPHEN_BYTE);
	assign bc.c    = text_byte;

	// cell row; a match may not start on a newline
	assign act_ext[0]     = !bc.nl;
	assign eq_ext[NCELL]  = 1'b0;

	for (genvar j = 0; j < NCELL; j++) begin : g_cell
		pcsb_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.bc       (bc),
			.pat_byte (pat_all[8*j +: 8]),
			.in_use   (LEN_W'(j) < len_used),
			.keep     (LEN_W'(j + 1) < len_used),
			.tail     (LEN_W'(j + 1) == len_used),
			.prev_act (act_ext[j]),
			.eq_next  (eq_ext[j+1]),
			.eq       (eq[j]),
			.act      (act[j]),
			.pend     (pend[j]),
			.done     (done[j])
		);
		assign eq_ext[j]    = eq[j];
		assign act_ext[j+1] = act[j];
	end

	assign hit   = |done;
	assign cnt_d = (hit && (cnt_q != COUNT_MAX)) ? cnt_q + 1'b1 : cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (acc) begin
			cnt_q <= end_of_text ? '0 : cnt_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (acc) begin
			valid_q <= 1'b1;
		end else if (!result_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			hit_q   <= hit;
			count_q <= cnt_d;
			done_q  <= end_of_text;
		end
	end

	assign result_valid = valid_q;
	assign match_here   = hit_q;
	assign match_count  = count_q;
	assign text_done    = done_q;

	`PCSB_ASSERT(a_hit_counts, valid_q && hit_q |-> count_q != '0, "match beat with zero count")
	`PCSB_ASSERT(a_eot_clears, acc && end_of_text |=> act == '0 && pend == '0 && cnt_q == '0, "state not cleared after end of text")
	`PCSB_ASSERT(a_pend_hyphen, acc && !bc.hy |=> pend == '0, "pending bit without hyphen")
	`PCSB_ASSERT(a_cnt_mono, acc && !end_of_text |=> cnt_q >= $past(cnt_q), "count decreased inside a text")
	`PCSB_ASSERT_ALWAYS(a_stall_src, text_stall |-> valid_q, "input stalled with empty output register")

endmodule

@@ hdl/pcsb_cell.sv @@
// ---------------------------------------------------------------------------
// pcsb_cell
// One pattern position: byte compare, partial-match and pending-hyphen bits.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcsb_cell import pcsb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  bcast_t     bc,
	input  logic [7:0] pat_byte,
	input  logic       in_use,
	input  logic       keep,
	input  logic       tail,
	input  logic       prev_act,
	input  logic       eq_next,
	output logic       eq,
	output logic       act,
	output logic       pend,
	output logic       done
);

	logic act_q;
	logic pend_q;
	logic raw;
	logic pend_d;

	assign eq     = in_use && (pat_byte == bc.c);
	assign raw    = (prev_act && eq) || (bc.nl && ((act_q && !eq_next) || pend_q));
	assign pend_d = bc.hy && act_q && !eq_next;
	assign done   = raw && tail;
	assign act    = act_q;
	assign pend   = pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q  <= 1'b0;
			pend_q <= 1'b0;
		end else if (bc.adv) begin
			if (bc.last) begin
				act_q  <= 1'b0;
				pend_q <= 1'b0;
			end else begin
				act_q  <= raw && keep;
				pend_q <= pend_d && keep;
			end
		end
	end

endmodule
